/* hdl/bgr_pkg.sv */
// Shared types and constants for the bilinear greyscale resizer.
// Used by every module of the block but bgr_ram; depends on nothing else.
`default_nettype none

package bgr_pkg;

  localparam int COORD_W   = 9;
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 10;
  localparam int CFG_IDX_W = 1;

  // Input word kinds.
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

  // Row and column that travel with a word.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } pos_t;

  // Bank parity of the four neighbour rows and columns.
  typedef struct packed {
    logic r1;
    logic r2;
    logic c1;
    logic c2;
  } par_t;

endpackage

`default_nettype wire

/* hdl/bgr_ram.sv */
// Generic simple dual-port RAM with a registered read port.
// Stand-alone; used for the frame store banks.
`default_nettype none

module bgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/bgr_map.sv */
// Coordinate mapping pipeline: three stages that turn an output pixel position
// into neighbour indices and fractional weights. Depends on bgr_pkg.
`default_nettype none

module bgr_map #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int OUT_SIDE   = 299
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire bgr_pkg::req_t                          kind,
  input  wire logic [bgr_pkg::COORD_W-1:0]            src_row,
  input  wire logic [bgr_pkg::COORD_W-1:0]            src_col,
  input  wire logic [bgr_pkg::PIX_W-1:0]              pixel_in,
  input  wire logic [bgr_pkg::COORD_W-1:0]            out_row,
  input  wire logic [bgr_pkg::COORD_W-1:0]            out_col,
  input  wire logic [bgr_pkg::DIM_W-1:0]              hm1,
  input  wire logic [bgr_pkg::DIM_W-1:0]              wm1,
  output logic                                        m_valid,
  input  wire logic                                   m_ready,
  output bgr_pkg::req_t                               m_kind,
  output bgr_pkg::pos_t                               m_pos,
  output logic [bgr_pkg::PIX_W-1:0]                   m_pix,
  output logic [$clog2(MAX_HEIGHT)-1:0]               m_r1,
  output logic [$clog2(MAX_HEIGHT)-1:0]               m_r2,
  output logic [$clog2(MAX_WIDTH)-1:0]                m_c1,
  output logic [$clog2(MAX_WIDTH)-1:0]                m_c2,
  output logic [$clog2(OUT_SIDE+1)-1:0]               m_fy,
  output logic [$clog2(OUT_SIDE+1)-1:0]               m_fx
);

  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int FW  = $clog2(OUT_SIDE + 1);
  localparam int PW  = bgr_pkg::COORD_W + bgr_pkg::DIM_W;
  // Reciprocal of OUT_SIDE, exact for every PW-bit numerator.
  localparam int          K1    = PW + $clog2(OUT_SIDE);
  localparam logic [63:0] RECIP = ((64'd1 << K1) + 64'(OUT_SIDE) - 64'd1) / 64'(OUT_SIDE);
  localparam int          MW    = $clog2(RECIP + 64'd1);
  localparam int          XW    = PW + MW;

  logic en1, en2, en3;
  logic v1, v2, v3;
  logic keep;

  bgr_pkg::req_t kind1, kind2, kind3;
  bgr_pkg::pos_t pos1, pos2, pos3;
  logic [bgr_pkg::PIX_W-1:0] pix1, pix2, pix3;
  logic [PW-1:0] py1, px1, py2, px2, qy2, qx2;
  logic [XW-1:0] prod_y, prod_x;
  logic [PW-1:0] r1c, r2c, c1c, c2c;
  logic [FW-1:0] fy_c, fx_c;
  logic [RW-1:0] r1, r2;
  logic [CW-1:0] c1, c2;
  logic [FW-1:0] fy3, fx3;

  assign en3      = !v3 || m_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Out-of-range writes and requests are dropped on entry.
  always_comb begin
    if (kind == bgr_pkg::REQ_WRITE) begin
      keep = (32'(src_row) < MAX_HEIGHT) && (32'(src_col) < MAX_WIDTH);
    end else begin
      keep = (32'(out_row) < OUT_SIDE) && (32'(out_col) < OUT_SIDE);
    end
  end

  assign prod_y = XW'(py1) * XW'(RECIP);
  assign prod_x = XW'(px1) * XW'(RECIP);

  always_comb begin
    fy_c = FW'(py2 - qy2 * PW'(OUT_SIDE));
    fx_c = FW'(px2 - qx2 * PW'(OUT_SIDE));
    r1c  = (qy2 > PW'(hm1)) ? PW'(hm1) : qy2;
    c1c  = (qx2 > PW'(wm1)) ? PW'(wm1) : qx2;
    r2c  = (r1c == PW'(hm1)) ? r1c : r1c + PW'(1);
    c2c  = (c1c == PW'(wm1)) ? c1c : c1c + PW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid && keep;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      kind1 <= kind;
      pos1  <= (kind == bgr_pkg::REQ_WRITE) ? bgr_pkg::pos_t'({src_row, src_col})
                                            : bgr_pkg::pos_t'({out_row, out_col});
      pix1  <= pixel_in;
      py1   <= PW'(out_row) * PW'(hm1);
      px1   <= PW'(out_col) * PW'(wm1);
    end
    if (en2) begin
      kind2 <= kind1;
      pos2  <= pos1;
      pix2  <= pix1;
      py2   <= py1;
      px2   <= px1;
      qy2   <= PW'(prod_y >> K1);
      qx2   <= PW'(prod_x >> K1);
    end
    if (en3) begin
      kind3 <= kind2;
      pos3  <= pos2;
      pix3  <= pix2;
      r1    <= RW'(r1c);
      r2    <= RW'(r2c);
      c1    <= CW'(c1c);
      c2    <= CW'(c2c);
      fy3   <= fy_c;
      fx3   <= fx_c;
    end
  end

  assign m_valid = v3;
  assign m_kind  = kind3;
  assign m_pos   = pos3;
  assign m_pix   = pix3;
  assign m_r1    = r1;
  assign m_r2    = r2;
  assign m_c1    = c1;
  assign m_c2    = c2;
  assign m_fy    = fy3;
  assign m_fx    = fx3;

endmodule

`default_nettype wire

/* hdl/bgr_store.sv */
// Frame store stage: four banks split by row and column parity so that the
// four neighbours are read together. Depends on bgr_pkg and bgr_ram.
`default_nettype none

module bgr_store #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int OUT_SIDE   = 299
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bgr_pkg::req_t                     kind,
  input  wire bgr_pkg::pos_t                     pos,
  input  wire logic [bgr_pkg::PIX_W-1:0]         pix,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0]     r1,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0]     r2,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      c1,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      c2,
  input  wire logic [$clog2(OUT_SIDE+1)-1:0]     fy,
  input  wire logic [$clog2(OUT_SIDE+1)-1:0]     fx,
  output logic                                   s_valid,
  input  wire logic                              s_ready,
  output bgr_pkg::pos_t                          s_pos,
  output bgr_pkg::par_t                          s_par,
  output logic [$clog2(OUT_SIDE+1)-1:0]          s_fy,
  output logic [$clog2(OUT_SIDE+1)-1:0]          s_fx,
  output logic [3:0][bgr_pkg::PIX_W-1:0]         s_pix
);

  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int BANK_DEPTH = HALF_H * HALF_W;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic          v;
  logic          fire;
  logic          rd_en;
  logic [RW-1:0] wrow;
  logic [CW-1:0] wcol;
  logic [AW-1:0] waddr;
  logic [3:0]    we;
  logic [3:0][AW-1:0] raddr;

  assign in_ready = !v || s_ready;
  assign fire     = in_valid && in_ready;
  assign rd_en    = fire && (kind == bgr_pkg::REQ_READ);

  assign wrow  = RW'(pos.row);
  assign wcol  = CW'(pos.col);
  assign waddr = AW'(AW'(wrow >> 1) * AW'(HALF_W) + AW'(wcol >> 1));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic P = 1'(b >> 1);
    localparam logic Q = 1'(b & 1);

    logic [RW-1:0] brow;
    logic [CW-1:0] bcol;

    // Each bank serves whichever neighbour row and column has its parity.
    assign brow     = (r1[0] == P) ? r1 : r2;
    assign bcol     = (c1[0] == Q) ? c1 : c2;
    assign raddr[b] = AW'(AW'(brow >> 1) * AW'(HALF_W) + AW'(bcol >> 1));
    assign we[b]    = fire && (kind == bgr_pkg::REQ_WRITE) && (wrow[0] == P)
                      && (wcol[0] == Q);

    bgr_ram #(
      .WIDTH(bgr_pkg::PIX_W),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (we[b]),
      .waddr(waddr),
      .wdata(pix),
      .re   (rd_en),
      .raddr(raddr[b]),
      .rdata(s_pix[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s_pos <= pos;
      s_par <= '{r1: r1[0], r2: r2[0], c1: c1[0], c2: c2[0]};
      s_fy  <= fy;
      s_fx  <= fx;
    end
  end

  assign s_valid = v;

endmodule

`default_nettype wire

/* hdl/bgr_blend.sv */
// Weighting pipeline: horizontal blend, vertical blend, then the scaled
// division that yields the output grey value. Depends on bgr_pkg.
`default_nettype none

module bgr_blend #(
  parameter int OUT_SIDE = 299
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bgr_pkg::pos_t                     pos,
  input  wire bgr_pkg::par_t                     par,
  input  wire logic [$clog2(OUT_SIDE+1)-1:0]     fy,
  input  wire logic [$clog2(OUT_SIDE+1)-1:0]     fx,
  input  wire logic [3:0][bgr_pkg::PIX_W-1:0]    pix,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bgr_pkg::pos_t                          res_pos,
  output logic [bgr_pkg::PIX_W-1:0]              value
);

  localparam int FW = $clog2(OUT_SIDE + 1);
  localparam int HW = bgr_pkg::PIX_W + FW;
  localparam int SW = bgr_pkg::PIX_W + 2 * FW;
  localparam int D2 = OUT_SIDE * OUT_SIDE;
  // Reciprocal of OUT_SIDE squared, exact for every SW-bit numerator.
  localparam int          K2    = SW + $clog2(D2);
  localparam logic [63:0] RECIP = ((64'd1 << K2) + 64'(D2) - 64'd1) / 64'(D2);
  localparam int          MW    = $clog2(RECIP + 64'd1);
  localparam int          XW    = SW + MW;

  logic en5, en6, en7;
  logic v5, v6, v7;

  logic [bgr_pkg::PIX_W-1:0] p_tl, p_tr, p_bl, p_br;
  logic [FW-1:0] wx0, wy0_c;
  logic [HW-1:0] top_c, bot_c;
  logic [HW-1:0] top5, bot5;
  logic [FW-1:0] wy0, wy1;
  logic [SW-1:0] sum6;
  logic [XW-1:0] prod;
  bgr_pkg::pos_t pos5, pos6, pos7;
  logic [bgr_pkg::PIX_W-1:0] val7;

  assign en7      = !v7 || out_ready;
  assign en6      = !v6 || en7;
  assign en5      = !v5 || en6;
  assign in_ready = en5;

  always_comb begin
    p_tl  = pix[{par.r1, par.c1}];
    p_tr  = pix[{par.r1, par.c2}];
    p_bl  = pix[{par.r2, par.c1}];
    p_br  = pix[{par.r2, par.c2}];
    wx0   = FW'(OUT_SIDE) - fx;
    wy0_c = FW'(OUT_SIDE) - fy;
    top_c = HW'(p_tl) * HW'(wx0) + HW'(p_tr) * HW'(fx);
    bot_c = HW'(p_bl) * HW'(wx0) + HW'(p_br) * HW'(fx);
  end

  assign prod = XW'(sum6) * XW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en5) begin
        v5 <= in_valid;
      end
      if (en6) begin
        v6 <= v5;
      end
      if (en7) begin
        v7 <= v6;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      pos5 <= pos;
      top5 <= top_c;
      bot5 <= bot_c;
      wy0  <= wy0_c;
      wy1  <= fy;
    end
    if (en6) begin
      pos6 <= pos5;
      sum6 <= SW'(top5) * SW'(wy0) + SW'(bot5) * SW'(wy1);
    end
    if (en7) begin
      pos7 <= pos6;
      val7 <= bgr_pkg::PIX_W'(prod >> K2);
    end
  end

  assign out_valid = v7;
  assign res_pos   = pos7;
  assign value     = val7;

endmodule

`default_nettype wire

/* hdl/bilinear_grey_resizer.sv */
// Top level of the bilinear greyscale resizer: configuration registers and
// the map, store and blend pipeline. Depends on bgr_pkg and all bgr_ modules.
//
// Usage. The input channel (in_valid/in_ready) carries one word per request.
// A word with req_type write stores pixel_in at (src_row, src_col) in the
// frame store and yields nothing. A word with req_type read asks for output
// pixel (out_row, out_col) of the OUT_SIDE by OUT_SIDE image; its result word
// leaves on the output channel (out_valid/out_ready) with the same row and
// column and the interpolated grey value. Words outside the store or outside
// the output square are dropped. Results leave in request order.
// There are seven register stages: three mapping stages (the product, the
// reciprocal multiply, the remainder and clamp), one frame store read, and
// three blend stages. One word is accepted in every cycle while the receiver
// keeps up. Each stage carries its own valid bit and advances when the
// next stage has room, so a stalled receiver only holds the words that are in
// its way and bubbles still close up; nothing is lost or repeated.
// Reset clears all valid bits and sets both dimensions to 512; the frame
// store is not cleared and must be loaded before it is read.
// Configuration writes (cfg_write, cfg_addr, cfg_data) take effect at once
// and must only be issued while no request is in flight.
`default_nettype none

module bilinear_grey_resizer #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int OUT_SIDE   = 299
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [bgr_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [bgr_pkg::DIM_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              req_type,
  input  wire logic [bgr_pkg::COORD_W-1:0]       src_row,
  input  wire logic [bgr_pkg::COORD_W-1:0]       src_col,
  input  wire logic [bgr_pkg::PIX_W-1:0]         pixel_in,
  input  wire logic [bgr_pkg::COORD_W-1:0]       out_row,
  input  wire logic [bgr_pkg::COORD_W-1:0]       out_col,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [bgr_pkg::COORD_W-1:0]            res_row,
  output logic [bgr_pkg::COORD_W-1:0]            res_col,
  output logic [bgr_pkg::PIX_W-1:0]              out_value
);

  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(OUT_SIDE + 1);

  // Effective dimension minus one: zero counts as one, large values saturate.
  function automatic logic [bgr_pkg::DIM_W-1:0] dim_m1(
    input logic [bgr_pkg::DIM_W-1:0] dim,
    input int                        max_dim
  );
    logic [bgr_pkg::DIM_W-1:0] res;
    if (dim == '0) begin
      res = '0;
    end else if (32'(dim) > max_dim) begin
      res = bgr_pkg::DIM_W'(max_dim - 1);
    end else begin
      res = dim - bgr_pkg::DIM_W'(1);
    end
    return res;
  endfunction

  // The registers hold the effective dimensions minus one, which is what
  // both the position scaling and the edge clamp need.
  logic [bgr_pkg::DIM_W-1:0] hm1, wm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wm1 <= dim_m1(bgr_pkg::DIM_W'(512), MAX_WIDTH);
      hm1 <= dim_m1(bgr_pkg::DIM_W'(512), MAX_HEIGHT);
    end else if (cfg_write) begin
      case (cfg_addr)
        bgr_pkg::REG_SRC_WIDTH: begin
          wm1 <= dim_m1(cfg_data, MAX_WIDTH);
        end
        bgr_pkg::REG_SRC_HEIGHT: begin
          hm1 <= dim_m1(cfg_data, MAX_HEIGHT);
        end
        default: begin
        end
      endcase
    end
  end

  // Mapping stages to frame store.
  logic          m_valid, m_ready;
  bgr_pkg::req_t m_kind;
  bgr_pkg::pos_t m_pos;
  logic [bgr_pkg::PIX_W-1:0] m_pix;
  logic [RW-1:0] m_r1, m_r2;
  logic [CW-1:0] m_c1, m_c2;
  logic [FW-1:0] m_fy, m_fx;

  // Frame store to blend stages.
  logic          s_valid, s_ready;
  bgr_pkg::pos_t s_pos;
  bgr_pkg::par_t s_par;
  logic [FW-1:0] s_fy, s_fx;
  logic [3:0][bgr_pkg::PIX_W-1:0] s_pix;

  bgr_pkg::pos_t res_pos;

  bgr_map #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .OUT_SIDE  (OUT_SIDE)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind    (bgr_pkg::req_t'(req_type)),
    .src_row (src_row),
    .src_col (src_col),
    .pixel_in(pixel_in),
    .out_row (out_row),
    .out_col (out_col),
    .hm1     (hm1),
    .wm1     (wm1),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_kind  (m_kind),
    .m_pos   (m_pos),
    .m_pix   (m_pix),
    .m_r1    (m_r1),
    .m_r2    (m_r2),
    .m_c1    (m_c1),
    .m_c2    (m_c2),
    .m_fy    (m_fy),
    .m_fx    (m_fx)
  );

  bgr_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .OUT_SIDE  (OUT_SIDE)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .in_valid(m_valid),
    .in_ready(m_ready),
    .kind    (m_kind),
    .pos     (m_pos),
    .pix     (m_pix),
    .r1      (m_r1),
    .r2      (m_r2),
    .c1      (m_c1),
    .c2      (m_c2),
    .fy      (m_fy),
    .fx      (m_fx),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_pos   (s_pos),
    .s_par   (s_par),
    .s_fy    (s_fy),
    .s_fx    (s_fx),
    .s_pix   (s_pix)
  );

  bgr_blend #(
    .OUT_SIDE(OUT_SIDE)
  ) u_blend (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_valid),
    .in_ready (s_ready),
    .pos      (s_pos),
    .par      (s_par),
    .fy       (s_fy),
    .fx       (s_fx),
    .pix      (s_pix),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res_pos  (res_pos),
    .value    (out_value)
  );

  assign res_row = res_pos.row;
  assign res_col = res_pos.col;

  // Only requests inside the output square may produce a result.
  a_res_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(res_row) < OUT_SIDE) && (32'(res_col) < OUT_SIDE))
    else $error("result outside the output square");

  // With the output register empty, the whole pipeline must have room.
  a_no_deadlock: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output is empty");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s_valid && !m_valid)
    else $error("pipeline holds a word after reset");

  // A result can only appear once the store stage held a word.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s_valid, 3))
    else $error("result without a matching store read");

endmodule

`default_nettype wire

/* verif/tb_bilinear_grey_resizer.sv */
// Testbench for bilinear_grey_resizer: drives write and request words, predicts each
// blended pixel and checks the result words in order. Depends on bgr_pkg and the RTL.

module tb_bilinear_grey_resizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W       = 512;
  localparam int MAX_H       = 512;
  localparam int OUT_SIDE    = 299;
  localparam int IDLE_PCT    = 24;    // chance in a hundred that a side idles in a cycle
  localparam int HOLD_CYCLES = 300;   // length of the long receiver hold-off
  localparam int SETTLE      = 12;    // cycles to let writes pass the seven-stage pipe
  localparam int QUIET_LIMIT = 3000;  // cycles with no accepted word before giving up
  localparam int WORDS_TOTAL = 1650;

  // One input word as the sender offers it.
  typedef struct {
    bgr_pkg::req_t               kind;
    logic [bgr_pkg::COORD_W-1:0] srow;
    logic [bgr_pkg::COORD_W-1:0] scol;
    logic [bgr_pkg::PIX_W-1:0]   pix;
    logic [bgr_pkg::COORD_W-1:0] orow;
    logic [bgr_pkg::COORD_W-1:0] ocol;
  } grey_word_t;

  // One blended output pixel.
  typedef struct {
    logic [bgr_pkg::COORD_W-1:0] row;
    logic [bgr_pkg::COORD_W-1:0] col;
    logic [bgr_pkg::PIX_W-1:0]   value;
  } blended_t;

  // Source neighbourhood of one output pixel: the four corner rows and columns and
  // the fractional weights, kept exactly as remainders over OUT_SIDE.
  typedef struct {
    int unsigned r1, r2, c1, c2, fy, fx;
  } corners_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [bgr_pkg::CFG_IDX_W-1:0] cfg_addr = bgr_pkg::REG_SRC_WIDTH;
  logic [bgr_pkg::DIM_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          req_type = bgr_pkg::REQ_WRITE;
  logic [bgr_pkg::COORD_W-1:0]   src_row = '0;
  logic [bgr_pkg::COORD_W-1:0]   src_col = '0;
  logic [bgr_pkg::PIX_W-1:0]     pixel_in = '0;
  logic [bgr_pkg::COORD_W-1:0]   out_row = '0;
  logic [bgr_pkg::COORD_W-1:0]   out_col = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [bgr_pkg::COORD_W-1:0]   res_row;
  logic [bgr_pkg::COORD_W-1:0]   res_col;
  logic [bgr_pkg::PIX_W-1:0]     out_value;

  bilinear_grey_resizer #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .OUT_SIDE  (OUT_SIDE)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .src_row  (src_row),
    .src_col  (src_col),
    .pixel_in (pixel_in),
    .out_row  (out_row),
    .out_col  (out_col),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res_row  (res_row),
    .res_col  (res_col),
    .out_value(out_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting for the driver, and blended pixels waiting for their result word.
  grey_word_t pending_words[$];
  blended_t   expected_pixels[$];

  // The predictor's own copy of the frame store and of the two size registers.
  bit [bgr_pkg::PIX_W-1:0] grey_store [MAX_W*MAX_H];
  logic [bgr_pkg::DIM_W-1:0] width_reg  = bgr_pkg::DIM_W'(512);
  logic [bgr_pkg::DIM_W-1:0] height_reg = bgr_pkg::DIM_W'(512);

  // Store entries that some queued write will have filled. Requests are only built
  // once all four of their corners are in here, so no unwritten entry is ever read.
  bit staged [MAX_W*MAX_H];

  bit calm = 1'b0;        // while set, neither side idles
  int hold_asks = 0;      // bumped to ask the receiver for one long hold-off
  int quiet_cycles = 0;
  int errors = 0;
  int words_planned = 0;
  int writes_seen = 0;
  int pixels_checked = 0;
  int requests_dropped = 0;
  int size_settings = 0;

  function automatic int unsigned store_addr(int unsigned r, int unsigned c);
    return r * MAX_W + c;
  endfunction

  // A zero register means one pixel; anything past the store saturates.
  function automatic int unsigned dim_used(logic [bgr_pkg::DIM_W-1:0] setting,
                                           int unsigned limit);
    if (setting == '0) return 1;
    return (setting > limit) ? limit : setting;
  endfunction

  function automatic corners_t corners_of(int unsigned orow, int unsigned ocol);
    corners_t k;
    int unsigned w, h, py, pc;
    w = dim_used(width_reg, MAX_W);
    h = dim_used(height_reg, MAX_H);
    py = orow * (h - 1);
    pc = ocol * (w - 1);
    k.r1 = py / OUT_SIDE;
    k.fy = py % OUT_SIDE;
    k.c1 = pc / OUT_SIDE;
    k.fx = pc % OUT_SIDE;
    if (k.r1 > h - 1) k.r1 = h - 1;
    if (k.c1 > w - 1) k.c1 = w - 1;
    // The far neighbours clamp to the last row and column, which also covers a
    // source that is a single pixel wide or tall.
    k.r2 = (k.r1 + 1 > h - 1) ? h - 1 : k.r1 + 1;
    k.c2 = (k.c1 + 1 > w - 1) ? w - 1 : k.c1 + 1;
    return k;
  endfunction

  // Weighted sum of the four neighbours over OUT_SIDE squared, truncated.
  function automatic blended_t blend_pixel(logic [bgr_pkg::COORD_W-1:0] orow,
                                           logic [bgr_pkg::COORD_W-1:0] ocol);
    corners_t k;
    longint unsigned wy0, wy1, wx0, wx1, acc;
    blended_t b;
    k = corners_of(orow, ocol);
    wy1 = k.fy;
    wy0 = OUT_SIDE - k.fy;
    wx1 = k.fx;
    wx0 = OUT_SIDE - k.fx;
    acc = grey_store[store_addr(k.r1, k.c1)] * wy0 * wx0
        + grey_store[store_addr(k.r2, k.c1)] * wy1 * wx0
        + grey_store[store_addr(k.r1, k.c2)] * wy0 * wx1
        + grey_store[store_addr(k.r2, k.c2)] * wy1 * wx1;
    acc = acc / (OUT_SIDE * OUT_SIDE);
    b.row   = orow;
    b.col   = ocol;
    b.value = acc[bgr_pkg::PIX_W-1:0];
    return b;
  endfunction

  // Callers fill the fields that the word kind does not use with random junk, so their bits move too.
  task automatic queue_word(bgr_pkg::req_t kind, int unsigned sr, int unsigned sc,
                            int unsigned pix, int unsigned orow, int unsigned ocol);
    grey_word_t wd;
    wd.kind = kind;
    wd.srow = bgr_pkg::COORD_W'(sr);
    wd.scol = bgr_pkg::COORD_W'(sc);
    wd.pix  = bgr_pkg::PIX_W'(pix);
    wd.orow = bgr_pkg::COORD_W'(orow);
    wd.ocol = bgr_pkg::COORD_W'(ocol);
    pending_words = {pending_words, wd};
    words_planned++;
  endtask

  task automatic stage_pixel(int unsigned r, int unsigned c, int unsigned pix);
    staged[store_addr(r, c)] = 1'b1;
    queue_word(bgr_pkg::REQ_WRITE, r, c, pix, $urandom_range(511), $urandom_range(511));
  endtask

  // Queue a request; a request inside the output square is preceded by writes to
  // any of its corners that nothing has filled yet.
  task automatic stage_request(int unsigned orow, int unsigned ocol);
    corners_t k;
    if (orow < OUT_SIDE && ocol < OUT_SIDE) begin
      k = corners_of(orow, ocol);
      if (!staged[store_addr(k.r1, k.c1)]) stage_pixel(k.r1, k.c1, $urandom_range(255));
      if (!staged[store_addr(k.r2, k.c1)]) stage_pixel(k.r2, k.c1, $urandom_range(255));
      if (!staged[store_addr(k.r1, k.c2)]) stage_pixel(k.r1, k.c2, $urandom_range(255));
      if (!staged[store_addr(k.r2, k.c2)]) stage_pixel(k.r2, k.c2, $urandom_range(255));
    end
    queue_word(bgr_pkg::REQ_READ, $urandom_range(511), $urandom_range(511),
               $urandom_range(255), orow, ocol);
  endtask

  // Wait until every queued word is in and every result is out, then let any
  // trailing writes clear the pipe before anything else changes.
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_register(logic [bgr_pkg::CFG_IDX_W-1:0] idx,
                                logic [bgr_pkg::DIM_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == bgr_pkg::REG_SRC_WIDTH) width_reg = value;
    else height_reg = value;
    @(negedge clk);
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_register(bgr_pkg::REG_SRC_WIDTH, bgr_pkg::DIM_W'(w));
    write_register(bgr_pkg::REG_SRC_HEIGHT, bgr_pkg::DIM_W'(h));
    size_settings++;
  endtask

  // A size setting probed at the corners of the output square and one point inside.
  task automatic probe_size(int unsigned w, int unsigned h);
    set_size(w, h);
    stage_request(0, 0);
    stage_request(OUT_SIDE - 1, OUT_SIDE - 1);
    stage_request(0, OUT_SIDE - 1);
    stage_request(OUT_SIDE - 1, 0);
    stage_request($urandom_range(OUT_SIDE - 1), $urandom_range(OUT_SIDE - 1));
    drain();
  endtask

  // Mostly legal requests with their corner writes, the rest writes anywhere in the
  // store or inside the source, and requests that may fall outside the output square.
  task automatic random_phase(int count);
    int pick;
    int unsigned w, h;
    w = dim_used(width_reg, MAX_W);
    h = dim_used(height_reg, MAX_H);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 62)
        stage_request($urandom_range(OUT_SIDE - 1), $urandom_range(OUT_SIDE - 1));
      else if (pick < 68)
        stage_request($urandom_range(1) * (OUT_SIDE - 1), $urandom_range(OUT_SIDE - 1));
      else if (pick < 80)
        stage_request($urandom_range(511), $urandom_range(511));
      else if (pick < 90)
        stage_pixel($urandom_range(511), $urandom_range(511), $urandom_range(255));
      else
        stage_pixel($urandom_range(h - 1), $urandom_range(w - 1), $urandom_range(255));
    end
  endtask

  // Driver: a new word goes out when the channel is empty or its word was just taken.
  always @(posedge clk) begin : driver
    grey_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pending_words.pop_front();
        in_valid <= 1'b1;
        req_type <= nxt.kind;
        src_row  <= nxt.srow;
        src_col  <= nxt.scol;
        pixel_in <= nxt.pix;
        out_row  <= nxt.orow;
        out_col  <= nxt.ocol;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random idling, or a counted hold-off when one has been asked for.
  always @(posedge clk) begin : receiver
    int hold_seen;
    int hold_left;
    if (rst) begin
      out_ready <= 1'b0;
      hold_seen = hold_asks;
      hold_left = 0;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: every accepted input word updates the predictor; every accepted result
  // word is checked against the oldest expectation.
  always @(posedge clk) begin : monitor
    blended_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;

      if (in_valid && in_ready) begin
        if (req_type == bgr_pkg::REQ_WRITE) begin
          grey_store[store_addr(src_row, src_col)] = pixel_in;
          writes_seen++;
        end else if (out_row < OUT_SIDE && out_col < OUT_SIDE) begin
          expected_pixels = {expected_pixels, blend_pixel(out_row, out_col)};
        end else begin
          requests_dropped++;
        end
      end

      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result word with nothing expected: res_row %0d res_col %0d out_value %0d",
                 res_row, res_col, out_value);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (res_row !== want.row) begin
            $error("res_row: expected %0d, got %0d", want.row, res_row);
            errors++;
          end
          if (res_col !== want.col) begin
            $error("res_col: expected %0d, got %0d", want.col, res_col);
            errors++;
          end
          if (out_value !== want.value) begin
            $error("out_value: expected %0d, got %0d", want.value, out_value);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: a block that stops taking or giving words ends the run.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset size of 512 by 512: black and white corners of the
    // store, the four corners of the output square, and requests just outside it.
    stage_pixel(0, 0, 0);
    stage_pixel(0, 1, 255);
    stage_pixel(1, 0, 255);
    stage_pixel(1, 1, 0);
    stage_pixel(MAX_H - 1, MAX_W - 1, 255);
    stage_request(0, 0);
    stage_request(1, 1);
    stage_request(OUT_SIDE - 1, OUT_SIDE - 1);
    stage_request(0, OUT_SIDE - 1);
    stage_request(OUT_SIDE - 1, 0);
    stage_request(OUT_SIDE, 0);
    stage_request(0, OUT_SIDE);
    stage_request(511, 511);
    drain();

    // Register extremes: zero reads as one pixel, values past the store saturate,
    // and single-row or single-column sources exercise the edge clamp.
    probe_size(0, 0);
    probe_size(1023, 1);
    probe_size(1, 1023);
    probe_size(2, 2);
    probe_size(512, 512);
    probe_size(513, 0);

    // No idling at all, and a long receiver hold-off at the start so the pipe fills
    // and the block has to stall its input while the sender keeps offering.
    set_size(7, 6);
    calm = 1'b1;
    hold_asks++;
    random_phase(200);
    drain();
    calm = 1'b0;

    // Random sizes, mostly small, now and then anything the register can hold.
    while (words_planned < WORDS_TOTAL) begin
      if ($urandom_range(9) == 0) set_size($urandom_range(1023), $urandom_range(1023));
      else set_size($urandom_range(12), $urandom_range(12));
      random_phase(80);
      drain();
    end

    $display("Covered %0d size settings: %0d pixel writes, %0d blended pixels checked,",
             size_settings, writes_seen, pixels_checked);
    $display("and %0d requests outside the output square dropped.", requests_dropped);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
